/* design/mtiu_pkg.sv */
// ----------------------------------------------------------------------------
// mtiu_pkg
// Types, function codes and register indexes of the timer/interrupt unit.
// ----------------------------------------------------------------------------
package mtiu_pkg;

  localparam int NumTimersDef   = 4;
  localparam int CounterBitsDef = 8;

  localparam logic [2:0] FUNC_READ  = 3'd0;
  localparam logic [2:0] FUNC_WRITE = 3'd1;
  localparam logic [2:0] FUNC_TICK  = 3'd2;
  localparam logic [2:0] FUNC_DMA   = 3'd3;
  localparam logic [2:0] FUNC_ACK   = 3'd4;

  localparam logic [4:0] REG_GPIO   = 5'd0;
  localparam logic [4:0] REG_EDGE   = 5'd1;
  localparam logic [4:0] REG_DIR    = 5'd2;
  localparam logic [4:0] REG_IERH   = 5'd3;
  localparam logic [4:0] REG_IERL   = 5'd4;
  localparam logic [4:0] REG_IPRH   = 5'd5;
  localparam logic [4:0] REG_IPRL   = 5'd6;
  localparam logic [4:0] REG_ISRH   = 5'd7;
  localparam logic [4:0] REG_ISRL   = 5'd8;
  localparam logic [4:0] REG_IMRH   = 5'd9;
  localparam logic [4:0] REG_IMRL   = 5'd10;
  localparam logic [4:0] REG_VBASE  = 5'd11;
  localparam logic [4:0] REG_TACR   = 5'd12;
  localparam logic [4:0] REG_TBCR   = 5'd13;
  localparam logic [4:0] REG_TCDCR  = 5'd14;
  localparam logic [4:0] REG_TDATA0 = 5'd15;
  localparam logic [4:0] REG_TDATA3 = 5'd18;
  localparam logic [4:0] REG_SER0   = 5'd19;
  localparam logic [4:0] REG_SER4   = 5'd23;

  localparam logic [7:0] SPURIOUS_VEC = 8'h18;

  typedef struct packed {
    logic [2:0] func;
    logic [5:0] address;
    logic       access_wide;
    logic [7:0] write_data;
  } mtiu_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_request;
    logic [7:0] ack_vector;
  } mtiu_out_t;

  function automatic logic [7:0] divisor(input logic [2:0] sel);
    case (sel)
      3'd0:    divisor = 8'd1;
      3'd1:    divisor = 8'd4;
      3'd2:    divisor = 8'd10;
      3'd3:    divisor = 8'd16;
      3'd4:    divisor = 8'd50;
      3'd5:    divisor = 8'd64;
      3'd6:    divisor = 8'd100;
      default: divisor = 8'd200;
    endcase
  endfunction

  function automatic logic [3:0] irq_bit(input logic [1:0] t);
    case (t)
      2'd0:    irq_bit = 4'd13;
      2'd1:    irq_bit = 4'd8;
      2'd2:    irq_bit = 4'd5;
      default: irq_bit = 4'd4;
    endcase
  endfunction

endpackage

/* design/multifunction_timer_interrupt_unit.sv */
// ----------------------------------------------------------------------------
// multifunction_timer_interrupt_unit
// Register file, four prescaled timers and a 16-channel interrupt controller.
// ----------------------------------------------------------------------------
// usage:
//   in_valid/in_stall/in_data carry one bus access, timer tick, dma event or
//   interrupt acknowledge per transfer; out_valid/out_stall/out_data return
//   one result per item (read byte, irq request, acknowledge vector).
//   an item accepted at an edge updates all state and loads the result register
//   at that same edge; out_valid is high the next cycle. throughput is one item
//   per cycle unless a waiting result is stalled, set by the single pass from
//   state and input through the update logic into the result register.
//   the input is stalled only while a result waits and the receiver stalls
//   it; a result that is taken frees the slot for an item in the same cycle.
//   reset clears all registers to their power-up values (enable and mask
//   hold timer c only) and empties the result register.
// ----------------------------------------------------------------------------
module multifunction_timer_interrupt_unit
  import mtiu_pkg::*;
#(
  parameter int NUM_TIMERS   = NumTimersDef,
  parameter int COUNTER_BITS = CounterBitsDef
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  mtiu_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output mtiu_out_t out_data
);

  logic [7:0]  gpio_r, edge_r, dir_r, vbase_r;
  logic [15:0] ier_r, ipr_r, isr_r, imr_r;
  logic [4:0]  mode_r [NUM_TIMERS];
  logic [COUNTER_BITS-1:0] cnt_r [NUM_TIMERS];
  logic [COUNTER_BITS-1:0] rld_r [NUM_TIMERS];
  logic [7:0]  pre_r [NUM_TIMERS];
  logic        evt_r;
  logic [7:0]  ser_r [5];
  logic        out_valid_r;
  mtiu_out_t   out_r;

  logic [7:0]  gpio_nxt, edge_nxt, dir_nxt, vbase_nxt;
  logic [15:0] ier_nxt, ipr_nxt, isr_nxt, imr_nxt;
  logic [4:0]  mode_nxt [NUM_TIMERS];
  logic [COUNTER_BITS-1:0] cnt_nxt [NUM_TIMERS];
  logic [COUNTER_BITS-1:0] rld_nxt [NUM_TIMERS];
  logic [7:0]  pre_nxt [NUM_TIMERS];
  logic        evt_nxt;
  logic [7:0]  ser_nxt [5];
  mtiu_out_t   out_nxt;

  logic        accept;
  logic [6:0]  eff;
  logic [4:0]  idx;
  logic        odd;
  logic [15:0] live;
  logic [COUNTER_BITS-1:0] dec;
  logic        adv;
  logic [7:0]  pinc;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign eff       = {1'b0, in_data.address} + {6'd0, in_data.access_wide};
  assign idx       = eff[5:1];
  assign odd       = eff[0] && !eff[6];

  always_comb begin
    gpio_nxt  = gpio_r;
    edge_nxt  = edge_r;
    dir_nxt   = dir_r;
    vbase_nxt = vbase_r;
    ier_nxt   = ier_r;
    ipr_nxt   = ipr_r;
    isr_nxt   = isr_r;
    imr_nxt   = imr_r;
    mode_nxt  = mode_r;
    cnt_nxt   = cnt_r;
    rld_nxt   = rld_r;
    pre_nxt   = pre_r;
    evt_nxt   = evt_r;
    ser_nxt   = ser_r;
    out_nxt   = '0;
    live      = ipr_r & imr_r;
    dec       = '0;
    adv       = 1'b0;
    pinc      = '0;
    case (in_data.func)
      FUNC_READ: begin
        if (odd) begin
          case (idx)
            REG_GPIO:  out_nxt.read_data = gpio_r;
            REG_EDGE:  out_nxt.read_data = edge_r;
            REG_DIR:   out_nxt.read_data = dir_r;
            REG_IERH:  out_nxt.read_data = ier_r[15:8];
            REG_IERL:  out_nxt.read_data = ier_r[7:0];
            REG_IPRH:  out_nxt.read_data = ipr_r[15:8];
            REG_IPRL:  out_nxt.read_data = ipr_r[7:0];
            REG_ISRH:  out_nxt.read_data = isr_r[15:8];
            REG_ISRL:  out_nxt.read_data = isr_r[7:0];
            REG_IMRH:  out_nxt.read_data = imr_r[15:8];
            REG_IMRL:  out_nxt.read_data = imr_r[7:0];
            REG_VBASE: out_nxt.read_data = vbase_r;
            REG_TACR:  out_nxt.read_data = {3'd0, mode_r[0]};
            REG_TBCR:  out_nxt.read_data = {3'd0, mode_r[1]};
            REG_TCDCR: out_nxt.read_data = {1'b0, mode_r[2][2:0], 1'b0, mode_r[3][2:0]};
            default: begin
              if (idx inside {[REG_TDATA0:REG_TDATA3]})
                out_nxt.read_data = 8'(cnt_r[2'(idx - REG_TDATA0)]);
              else if (idx inside {[REG_SER0:REG_SER4]})
                out_nxt.read_data = ser_r[3'(idx - REG_SER0)];
            end
          endcase
        end
      end
      FUNC_WRITE: begin
        if (odd) begin
          case (idx)
            REG_GPIO:  gpio_nxt = in_data.write_data;
            REG_EDGE:  edge_nxt = in_data.write_data;
            REG_DIR:   dir_nxt = in_data.write_data;
            REG_IERH:  ier_nxt[15:8] = in_data.write_data;
            REG_IERL:  ier_nxt[7:0] = in_data.write_data;
            REG_IPRH:  ipr_nxt[15:8] = in_data.write_data;
            REG_IPRL:  ipr_nxt[7:0] = in_data.write_data;
            REG_ISRH:  isr_nxt[15:8] = in_data.write_data;
            REG_ISRL:  isr_nxt[7:0] = in_data.write_data;
            REG_IMRH:  imr_nxt[15:8] = in_data.write_data;
            REG_IMRL:  imr_nxt[7:0] = in_data.write_data;
            REG_VBASE: vbase_nxt = {in_data.write_data[7:3], 3'd0};
            REG_TACR: begin
              mode_nxt[0] = in_data.write_data[4:0];
              pre_nxt[0]  = '0;
            end
            REG_TBCR: begin
              mode_nxt[1] = in_data.write_data[4:0];
              pre_nxt[1]  = '0;
            end
            REG_TCDCR: begin
              mode_nxt[2] = {2'd0, in_data.write_data[6:4]};
              mode_nxt[3] = {2'd0, in_data.write_data[2:0]};
              pre_nxt[2]  = '0;
              pre_nxt[3]  = '0;
            end
            default: begin
              if (idx inside {[REG_TDATA0:REG_TDATA3]}) begin
                rld_nxt[2'(idx - REG_TDATA0)] = COUNTER_BITS'(in_data.write_data);
                if (mode_r[2'(idx - REG_TDATA0)][3:0] == 4'd0)
                  cnt_nxt[2'(idx - REG_TDATA0)] = COUNTER_BITS'(in_data.write_data);
              end else if (idx inside {[REG_SER0:REG_SER4]}) begin
                ser_nxt[3'(idx - REG_SER0)] = in_data.write_data;
              end
            end
          endcase
        end
      end
      FUNC_TICK: begin
        for (int t = 0; t < NUM_TIMERS; t++) begin
          adv  = 1'b0;
          pinc = pre_r[t] + 8'd1;
          dec  = cnt_r[t] - COUNTER_BITS'(1);
          if (mode_r[t][3:0] != 4'd0) begin
            pre_nxt[t] = pinc;
            if (pinc >= divisor(mode_r[t][2:0])) begin
              pre_nxt[t] = '0;
              if (!mode_r[t][3]) begin
                adv = 1'b1;
              end else if (mode_r[t][3:0] == 4'd8 && evt_nxt) begin
                evt_nxt = 1'b0;
                adv     = 1'b1;
              end
            end
          end
          if (adv) begin
            cnt_nxt[t] = dec;
            if (dec == '0) begin
              cnt_nxt[t] = rld_r[t];
              if (ier_r[irq_bit(2'(t))])
                ipr_nxt[irq_bit(2'(t))] = 1'b1;
            end
          end
        end
      end
      FUNC_DMA: begin
        if (mode_r[0][3:0] == 4'd8)
          evt_nxt = 1'b1;
        if (ier_r[15])
          ipr_nxt[15] = 1'b1;
      end
      FUNC_ACK: begin
        out_nxt.ack_vector = SPURIOUS_VEC;
        for (int c = 0; c < 16; c++) begin
          if (live[c]) begin
            ipr_nxt            = ipr_r & ~(16'd1 << c);
            out_nxt.ack_vector = {vbase_r[7:4], 4'(c)};
          end
        end
      end
      default: begin
      end
    endcase
    out_nxt.irq_request = |(ipr_nxt & imr_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gpio_r      <= '0;
      edge_r      <= '0;
      dir_r       <= '0;
      vbase_r     <= '0;
      ier_r       <= 16'h0020;
      ipr_r       <= '0;
      isr_r       <= '0;
      imr_r       <= 16'h0020;
      evt_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int t = 0; t < NUM_TIMERS; t++) begin
        mode_r[t] <= '0;
        cnt_r[t]  <= '0;
        rld_r[t]  <= '0;
        pre_r[t]  <= '0;
      end
      for (int s = 0; s < 5; s++) ser_r[s] <= '0;
    end else begin
      if (accept) begin
        gpio_r  <= gpio_nxt;
        edge_r  <= edge_nxt;
        dir_r   <= dir_nxt;
        vbase_r <= vbase_nxt;
        ier_r   <= ier_nxt;
        ipr_r   <= ipr_nxt;
        isr_r   <= isr_nxt;
        imr_r   <= imr_nxt;
        mode_r  <= mode_nxt;
        cnt_r   <= cnt_nxt;
        rld_r   <= rld_nxt;
        pre_r   <= pre_nxt;
        evt_r   <= evt_nxt;
        ser_r   <= ser_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_r <= out_nxt;
  end

  a_irq_req: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_data.irq_request == |(ipr_r & imr_r))
    else $error("irq request does not match pending and mask");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result lost");

  a_ack_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.func == FUNC_ACK && (ipr_r & imr_r) != 16'd0
    |=> $countones(ipr_r) == $countones($past(ipr_r)) - 1)
    else $error("acknowledge did not clear one pending bit");

endmodule
